// ===== src/acaf_pkg.sv =====
// Shared constants, types and the channel scale table for the ADC channel
// average filter. No dependencies; every other file in src uses this package.
package acaf_pkg;

    localparam int BLOCK_LENGTH = 32;
    localparam int NUM_CHANNELS = 8;
    localparam int SAMPLE_BITS  = 12;

    // Field widths of the sample and result beats.
    localparam int CHANNEL_W  = 4;
    localparam int OFFSET_W   = 12;
    localparam int FILTERED_W = 12;
    localparam int SCALED_W   = 15;

    // The block mean is a right shift, so BLOCK_LENGTH is a power of two.
    localparam int BLOCK_SHIFT = $clog2(BLOCK_LENGTH);
    localparam int SUM_W       = SAMPLE_BITS + BLOCK_SHIFT;
    localparam int COUNT_W     = BLOCK_SHIFT;
    localparam int IDX_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SCALE_W     = 3;

    localparam logic [OFFSET_W-1:0] ZERO_OFFSET_RESET = OFFSET_W'(90);

    // Channel numbers that carry a scale other than one.
    localparam logic [CHANNEL_W-1:0] CH_ONE  = CHANNEL_W'(1);
    localparam logic [CHANNEL_W-1:0] CH_TWO  = CHANNEL_W'(2);
    localparam logic [CHANNEL_W-1:0] CH_FOUR = CHANNEL_W'(4);
    localparam logic [CHANNEL_W-1:0] CH_FIVE = CHANNEL_W'(5);

    localparam logic [SCALE_W-1:0] SCALE_CH_ONE  = SCALE_W'(2);
    localparam logic [SCALE_W-1:0] SCALE_CH_TWO  = SCALE_W'(7);
    localparam logic [SCALE_W-1:0] SCALE_CH_FOUR = SCALE_W'(5);
    localparam logic [SCALE_W-1:0] SCALE_UNITY   = SCALE_W'(1);

    // Registered sample beat handed from the input stage to the datapath.
    typedef struct packed {
        logic                  valid;
        logic [CHANNEL_W-1:0]  channel;
        logic [SAMPLE_BITS-1:0] sample;
    } acaf_step_t;

    // Result computed for the sample in the input stage.
    typedef struct packed {
        logic                  emit;
        logic [CHANNEL_W-1:0]  out_channel;
        logic [FILTERED_W-1:0] filtered_value;
        logic [SCALED_W-1:0]   scaled_value;
    } acaf_result_t;

    function automatic logic [SCALE_W-1:0] channel_scale(input logic [CHANNEL_W-1:0] ch);
        logic [SCALE_W-1:0] scale;
        case (ch)
            CH_ONE:  scale = SCALE_CH_ONE;
            CH_TWO:  scale = SCALE_CH_TWO;
            CH_FOUR: scale = SCALE_CH_FOUR;
            CH_FIVE: scale = SCALE_CH_FOUR;
            default: scale = SCALE_UNITY;
        endcase
        return scale;
    endfunction

endpackage

// ===== src/acaf_sample_if.sv =====
// Valid/ready channel that carries one tagged ADC sample per beat.
// Depends on acaf_pkg for the field widths.
interface acaf_sample_if;
    logic                            valid;
    logic                            ready;
    logic [acaf_pkg::CHANNEL_W-1:0]  channel;
    logic [acaf_pkg::SAMPLE_BITS-1:0] sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

// ===== src/acaf_result_if.sv =====
// Valid/ready channel that carries one filtered block result per beat.
// Depends on acaf_pkg for the field widths.
interface acaf_result_if;
    logic                            valid;
    logic                            ready;
    logic [acaf_pkg::CHANNEL_W-1:0]  out_channel;
    logic [acaf_pkg::FILTERED_W-1:0] filtered_value;
    logic [acaf_pkg::SCALED_W-1:0]   scaled_value;

    modport source (output valid, output out_channel, output filtered_value,
                    output scaled_value, input ready);
    modport sink   (input valid, input out_channel, input filtered_value,
                    input scaled_value, output ready);
endinterface

// ===== src/acaf_in_reg.sv =====
// Input register of the filter: captures one sample beat and holds it until
// the datapath commits it. Depends on acaf_pkg and acaf_sample_if.
module acaf_in_reg
(
    input  logic                clk,
    input  logic                rst_n,
    acaf_sample_if.sink         samples,
    input  logic                advance,
    output acaf_pkg::acaf_step_t step
);

    logic                               valid_reg;
    logic                               valid_next;
    logic [acaf_pkg::CHANNEL_W-1:0]     channel_reg;
    logic [acaf_pkg::SAMPLE_BITS-1:0]   sample_reg;
    logic                               take;

    // The register refills in the same cycle that its item moves on.
    assign samples.ready = !valid_reg || advance;
    assign take          = samples.valid && samples.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            channel_reg <= samples.channel;
            sample_reg  <= samples.sample;
        end
    end

    assign step.valid   = valid_reg;
    assign step.channel = channel_reg;
    assign step.sample  = sample_reg;

endmodule

// ===== src/acaf_datapath.sv =====
// Per-channel block state and the single-pass block-end arithmetic.
// Depends on acaf_pkg.
module acaf_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  acaf_pkg::acaf_step_t              step,
    input  logic                              advance,
    input  logic [acaf_pkg::OFFSET_W-1:0]     zero_offset,
    output acaf_pkg::acaf_result_t            result
);

    logic [acaf_pkg::SUM_W-1:0]       sum_reg    [acaf_pkg::NUM_CHANNELS];
    logic [acaf_pkg::COUNT_W-1:0]     count_reg  [acaf_pkg::NUM_CHANNELS];
    logic [acaf_pkg::SAMPLE_BITS-1:0] smooth_reg [acaf_pkg::NUM_CHANNELS];

    logic                             hit;
    logic                             complete;
    logic                             commit;
    logic [acaf_pkg::IDX_W-1:0]       idx;
    logic [acaf_pkg::SUM_W-1:0]       sum_next;
    logic [acaf_pkg::COUNT_W-1:0]     count_next;
    logic [acaf_pkg::SAMPLE_BITS-1:0] mean;
    logic [acaf_pkg::SAMPLE_BITS:0]   pair_sum;
    logic [acaf_pkg::SAMPLE_BITS-1:0] avg;
    logic [acaf_pkg::SAMPLE_BITS:0]   offset_ext;
    logic [acaf_pkg::SAMPLE_BITS:0]   diff;
    logic [acaf_pkg::SAMPLE_BITS-1:0] smooth_next;

    // Channel zero and channels above the last one are dropped silently.
    assign hit = (step.channel != '0) &&
                 (step.channel <= acaf_pkg::CHANNEL_W'(acaf_pkg::NUM_CHANNELS));
    assign idx = acaf_pkg::IDX_W'(step.channel - acaf_pkg::CHANNEL_W'(1));

    assign sum_next   = sum_reg[idx] + acaf_pkg::SUM_W'(step.sample);
    assign count_next = count_reg[idx] + acaf_pkg::COUNT_W'(1);
    assign complete   = hit &&
                        (count_reg[idx] == acaf_pkg::COUNT_W'(acaf_pkg::BLOCK_LENGTH - 1));
    assign commit     = step.valid && advance && hit;

    // Block mean, averaged with the stored value, then the offset with a floor at zero.
    assign mean       = sum_next[acaf_pkg::SUM_W-1:acaf_pkg::BLOCK_SHIFT];
    assign pair_sum   = {1'b0, mean} + {1'b0, smooth_reg[idx]};
    assign avg        = pair_sum[acaf_pkg::SAMPLE_BITS:1];
    assign offset_ext = (acaf_pkg::SAMPLE_BITS + 1)'(zero_offset);
    assign diff       = {1'b0, avg} - offset_ext;

    always_comb
    begin
        if ({1'b0, avg} > offset_ext)
        begin
            smooth_next = diff[acaf_pkg::SAMPLE_BITS-1:0];
        end
        else
        begin
            smooth_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < acaf_pkg::NUM_CHANNELS; i++)
            begin
                sum_reg[i]    <= '0;
                count_reg[i]  <= '0;
                smooth_reg[i] <= '0;
            end
        end
        else if (commit)
        begin
            if (complete)
            begin
                sum_reg[idx]    <= '0;
                count_reg[idx]  <= '0;
                smooth_reg[idx] <= smooth_next;
            end
            else
            begin
                sum_reg[idx]   <= sum_next;
                count_reg[idx] <= count_next;
            end
        end
    end

    assign result.emit           = step.valid && complete;
    assign result.out_channel    = step.channel;
    assign result.filtered_value = acaf_pkg::FILTERED_W'(smooth_next);
    assign result.scaled_value   = acaf_pkg::SCALED_W'(
        acaf_pkg::SCALED_W'(smooth_next) *
        acaf_pkg::SCALED_W'(acaf_pkg::channel_scale(step.channel)));

    // A finished block leaves its channel ready for a fresh block.
    a_block_restart: assert property (@(posedge clk) disable iff (!rst_n)
        commit && complete |=> count_reg[$past(idx)] == '0 && sum_reg[$past(idx)] == '0)
        else $error("block state not cleared after block end");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        commit && !complete |=> count_reg[$past(idx)] == $past(count_next))
        else $error("block count did not advance by one");

    a_smooth_store: assert property (@(posedge clk) disable iff (!rst_n)
        commit && complete |=> smooth_reg[$past(idx)] == $past(smooth_next))
        else $error("smoothed value not stored at block end");

endmodule

// ===== src/adc_channel_average_filter_unit.sv =====
// Top level of the ADC channel average filter: offset register, stage control
// and the result register. Depends on acaf_pkg, both interfaces and the submodules.
//
// The filter takes one sample beat per clock cycle, tagged with a channel from
// one to eight, and keeps a 32-sample block sum, count and smoothed value per
// channel. On the last sample of a block it emits one result beat holding the
// new smoothed value (block mean averaged with the old value, less the zero
// offset, floored at zero) and a copy scaled by the channel factor. A sample
// goes into the input register on acceptance, the whole block arithmetic runs
// in the next cycle, and the result register, from which a result is offered,
// is loaded when the last sample of its block leaves the input register. The
// sustained rate is one sample per cycle; it drops only when a block ends while
// the previous result still waits in the output register, and then the input
// register holds that sample until the result side takes the waiting beat.
// Samples on channel zero or above eight are accepted and dropped. zero_offset
// resets to 90 and should be written only while no block end is in flight.
module adc_channel_average_filter_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [acaf_pkg::OFFSET_W-1:0] cfg_wdata,
    acaf_sample_if.sink                   samples,
    acaf_result_if.source                 results
);

    acaf_pkg::acaf_step_t                 step;
    acaf_pkg::acaf_result_t               result;
    logic                                 advance;
    logic                                 load;
    logic [acaf_pkg::OFFSET_W-1:0]        zero_offset_reg;
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic [acaf_pkg::CHANNEL_W-1:0]       out_channel_reg;
    logic [acaf_pkg::FILTERED_W-1:0]      filtered_reg;
    logic [acaf_pkg::SCALED_W-1:0]        scaled_reg;

    // An item without a result always moves on; one with a result needs room.
    assign advance = step.valid && (!result.emit || !out_valid_reg || results.ready);
    assign load    = advance && result.emit;

    acaf_in_reg u_in_reg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .advance (advance),
        .step    (step)
    );

    acaf_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .advance     (advance),
        .zero_offset (zero_offset_reg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_offset_reg <= acaf_pkg::ZERO_OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            zero_offset_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_channel_reg <= result.out_channel;
            filtered_reg    <= result.filtered_value;
            scaled_reg      <= result.scaled_value;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.out_channel    = out_channel_reg;
    assign results.filtered_value = filtered_reg;
    assign results.scaled_value   = scaled_reg;

    // A blocked item stays in the input register rather than being lost.
    a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        step.valid && !advance |=> step.valid && $stable(step.channel) &&
        $stable(step.sample))
        else $error("blocked sample left the input register");

    // A new result never lands on one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !out_valid_reg || results.ready)
        else $error("result register overwritten while full");

    a_scale_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.filtered_value == '0 |-> results.scaled_value == '0)
        else $error("scaled value nonzero for zero filtered value");

endmodule
